[rtl/incremental_pid_step_assert.svh]
// Assertion macros shared by the incremental PID step RTL.
`ifndef INCREMENTAL_PID_STEP_ASSERT_SVH
`define INCREMENTAL_PID_STEP_ASSERT_SVH

// Check that cons holds in the cycle after ante.
`define IPS_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("incremental_pid_step: next-cycle check failed");

// Check that cons holds in the same cycle as ante.
`define IPS_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("incremental_pid_step: same-cycle check failed");

`endif

[rtl/ips_pkg.sv]
// Package with constants, types and helpers of the incremental PID step.
`timescale 1ns / 1ps
package ips_pkg;

  localparam int IPS_SAMPLE_WIDTH    = 16;
  localparam int IPS_GAIN_FRAC_BITS  = 8;
  localparam int GAIN_WIDTH          = 16;
  localparam int TARGET_WIDTH        = 16;
  localparam int LIMIT_WIDTH         = 32;
  localparam int CFG_INDEX_WIDTH     = 3;
  localparam int CFG_DATA_WIDTH      = 32;
  localparam int QUEUE_DEPTH         = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_TARGET_VALUE = 3'd3,
    CFG_LIMIT_HIGH   = 3'd4,
    CFG_LIMIT_LOW    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic signed [GAIN_WIDTH-1:0]   gain_p;
    logic signed [GAIN_WIDTH-1:0]   gain_i;
    logic signed [GAIN_WIDTH-1:0]   gain_d;
    logic signed [TARGET_WIDTH-1:0] target_value;
    logic signed [LIMIT_WIDTH-1:0]  limit_high;
    logic signed [LIMIT_WIDTH-1:0]  limit_low;
  } cfg_t;

  // Error width: wide enough for target minus sample at any sample width.
  function automatic int err_width(input int sample_width);
    return ((sample_width > TARGET_WIDTH) ? sample_width : TARGET_WIDTH) + 1;
  endfunction

endpackage

[rtl/ips_channels.sv]
// Handshake interfaces for the sample, result and configuration channels.
`timescale 1ns / 1ps
interface ips_sample_if import ips_pkg::*; #(
  parameter int SAMPLE_WIDTH = IPS_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface ips_result_if import ips_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [LIMIT_WIDTH-1:0] drive_increment;
  logic                          was_clamped;

  modport source (output valid, output drive_increment, output was_clamped, input ready);
  modport sink   (input valid, input drive_increment, input was_clamped, output ready);
endinterface

interface ips_cfg_if import ips_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/incremental_pid_step.sv]
// Top level of the incremental (velocity-form) PID step.
`timescale 1ns / 1ps
// Each transferred sample yields one clamped increment,
// kp*(e-e1) + ki*e - kd*(e-2*e1+e2) shifted right by GAIN_FRAC_BITS, with
// e = target_value - sample_value. One sample is taken every cycle while the
// queue has room; its result passes through the queue slot, then the registered
// gain multipliers, then the sum, shift and clamp into the output register.
// The two-entry queue lets the sample side keep moving while the result side
// stalls. Reset clears the error history and sets the gains and target to
// zero and the limits to the full 32-bit range; write configuration only
// while no result is pending.
module incremental_pid_step import ips_pkg::*; #(
  parameter int SAMPLE_WIDTH   = IPS_SAMPLE_WIDTH,
  parameter int GAIN_FRAC_BITS = IPS_GAIN_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  ips_sample_if.sink   sample,
  ips_result_if.source result,
  ips_cfg_if.sink      cfg
);

  localparam int EW = err_width(SAMPLE_WIDTH);
  localparam int QW = EW + (EW + 1) + (EW + 2);

  cfg_t          regs;
  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;

  ips_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ips_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .regs       (regs),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ips_queue #(
    .DATA_WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ips_back #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

[rtl/ips_cfg_regs.sv]
// Configuration register file of the incremental PID step.
`timescale 1ns / 1ps
module ips_cfg_regs import ips_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ips_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_p       <= '0;
      regs.gain_i       <= '0;
      regs.gain_d       <= '0;
      regs.target_value <= '0;
      regs.limit_high   <= {1'b0, {(LIMIT_WIDTH-1){1'b1}}};
      regs.limit_low    <= {1'b1, {(LIMIT_WIDTH-1){1'b0}}};
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_GAIN_P:       regs.gain_p       <= cfg.data[GAIN_WIDTH-1:0];
        CFG_GAIN_I:       regs.gain_i       <= cfg.data[GAIN_WIDTH-1:0];
        CFG_GAIN_D:       regs.gain_d       <= cfg.data[GAIN_WIDTH-1:0];
        CFG_TARGET_VALUE: regs.target_value <= cfg.data[TARGET_WIDTH-1:0];
        CFG_LIMIT_HIGH:   regs.limit_high   <= cfg.data[LIMIT_WIDTH-1:0];
        CFG_LIMIT_LOW:    regs.limit_low    <= cfg.data[LIMIT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/ips_front.sv]
// Front end: takes samples, forms the error terms and keeps the error history.
`timescale 1ns / 1ps
module ips_front import ips_pkg::*; #(
  parameter int SAMPLE_WIDTH = IPS_SAMPLE_WIDTH,
  localparam int EW  = err_width(SAMPLE_WIDTH),
  localparam int DPW = EW + 1,
  localparam int DDW = EW + 2,
  localparam int QW  = EW + DPW + DDW
) (
  input  logic            clk,
  input  logic            rst,
  ips_sample_if.sink      sample,
  input  cfg_t            regs,
  output logic            push_valid,
  input  logic            push_ready,
  output logic [QW-1:0]   push_data
);

  logic signed [EW-1:0]  error_one_back;
  logic signed [EW-1:0]  error_two_back;
  logic signed [EW-1:0]  target_ext;
  logic signed [EW-1:0]  sample_ext;
  logic signed [EW-1:0]  err;
  logic signed [DPW-1:0] d_p;
  logic signed [DDW-1:0] d_d;
  logic                  take;

  assign sample.ready = push_ready;
  assign push_valid   = sample.valid;
  assign take         = sample.valid && push_ready;

  always_comb begin
    target_ext = EW'(regs.target_value);
    sample_ext = EW'(sample.sample_value);
    err        = target_ext - sample_ext;
    d_p        = DPW'(err) - DPW'(error_one_back);
    d_d        = DDW'(err) - (DDW'(error_one_back) <<< 1) + DDW'(error_two_back);
    push_data  = {err, d_p, d_d};
  end

  // Advance the error history on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_one_back <= '0;
      error_two_back <= '0;
    end else if (take) begin
      error_two_back <= error_one_back;
      error_one_back <= err;
    end
  end

endmodule

[rtl/ips_queue.sv]
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
`include "incremental_pid_step_assert.svh"
module ips_queue import ips_pkg::*; #(
  parameter int DATA_WIDTH = 1,
  localparam int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  logic [DATA_WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output logic [DATA_WIDTH-1:0] pop_data
);

  logic [DATA_WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  push;
  logic                  pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `IPS_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `IPS_ASSERT_NEXT(a_count_up, clk, rst, push && !pop && !rst, count == $past(count) + CNT_W'(1))
  `IPS_ASSERT_NEXT(a_count_down, clk, rst, pop && !push && !rst, count == $past(count) - CNT_W'(1))

endmodule

[rtl/ips_back.sv]
// Back end: gain products, sum, scaling shift and output clamp.
`timescale 1ns / 1ps
`include "incremental_pid_step_assert.svh"
module ips_back import ips_pkg::*; #(
  parameter int SAMPLE_WIDTH   = IPS_SAMPLE_WIDTH,
  parameter int GAIN_FRAC_BITS = IPS_GAIN_FRAC_BITS,
  localparam int EW   = err_width(SAMPLE_WIDTH),
  localparam int DPW  = EW + 1,
  localparam int DDW  = EW + 2,
  localparam int QW   = EW + DPW + DDW,
  localparam int PW   = DDW + GAIN_WIDTH,
  localparam int SUMW = PW + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          regs,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  logic [QW-1:0] pop_data,
  ips_result_if.source  result
);

  logic signed [EW-1:0]         err;
  logic signed [DPW-1:0]        d_p;
  logic signed [DDW-1:0]        d_d;
  logic signed [GAIN_WIDTH-1:0] gain_p;
  logic signed [GAIN_WIDTH-1:0] gain_i;
  logic signed [GAIN_WIDTH-1:0] gain_d;
  logic signed [PW-1:0]         prod_p;
  logic signed [PW-1:0]         prod_i;
  logic signed [PW-1:0]         prod_d;
  logic                         v1;
  logic                         v2;
  logic                         s1_adv;
  logic                         s2_adv;
  logic signed [SUMW-1:0]       sum;
  logic signed [SUMW-1:0]       scaled;
  logic signed [SUMW-1:0]       lo_ext;
  logic signed [SUMW-1:0]       hi_ext;
  logic signed [LIMIT_WIDTH-1:0] drive_next;
  logic                         clamp_next;

  assign err    = pop_data[QW-1 -: EW];
  assign d_p    = pop_data[DDW +: DPW];
  assign d_d    = pop_data[DDW-1:0];
  assign gain_p = regs.gain_p;
  assign gain_i = regs.gain_i;
  assign gain_d = regs.gain_d;

  assign s2_adv    = !v2 || result.ready;
  assign s1_adv    = !v1 || s2_adv;
  assign pop_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      prod_p <= PW'(gain_p) * PW'(d_p);
      prod_i <= PW'(gain_i) * PW'(err);
      prod_d <= PW'(gain_d) * PW'(d_d);
    end
  end

  always_comb begin
    sum    = SUMW'(prod_p) + SUMW'(prod_i) - SUMW'(prod_d);
    scaled = sum >>> GAIN_FRAC_BITS;
    lo_ext = SUMW'(regs.limit_low);
    hi_ext = SUMW'(regs.limit_high);
    if (scaled < lo_ext) begin
      drive_next = regs.limit_low;
      clamp_next = 1'b1;
    end else if (scaled > hi_ext) begin
      drive_next = regs.limit_high;
      clamp_next = 1'b1;
    end else begin
      drive_next = scaled[LIMIT_WIDTH-1:0];
      clamp_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      result.drive_increment <= drive_next;
      result.was_clamped     <= clamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (s1_adv) begin
        v1 <= pop_valid;
      end
      if (s2_adv) begin
        v2 <= v1;
      end
    end
  end

  assign result.valid = v2;

  `IPS_ASSERT_NEXT(a_stage_hold, clk, rst, v1 && !s2_adv && !rst, v1 && $stable(prod_p))

endmodule

[test/incremental_pid_step_tb.sv]
// Self-checking testbench for incremental_pid_step: directed and random samples against a predictor.
`timescale 1ns / 1ps
module incremental_pid_step_tb;
  import ips_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 730;
  localparam int CALM_ITEMS     = 100;
  localparam logic signed [GAIN_WIDTH-1:0]  S16_MIN = 16'sh8000;
  localparam logic signed [GAIN_WIDTH-1:0]  S16_MAX = 16'sh7fff;
  localparam logic signed [LIMIT_WIDTH-1:0] L32_MIN = 32'sh8000_0000;
  localparam logic signed [LIMIT_WIDTH-1:0] L32_MAX = 32'sh7fff_ffff;
  localparam logic [CFG_INDEX_WIDTH-1:0] SPARE_INDEX_A = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] SPARE_INDEX_B = 3'd7;

  typedef struct packed {
    logic signed [LIMIT_WIDTH-1:0] increment;
    logic                          clamped;
  } pid_result_t;

  class pid_scoreboard;
    logic signed [GAIN_WIDTH-1:0]     kp, ki, kd;
    logic signed [TARGET_WIDTH-1:0]   setpoint;
    logic signed [LIMIT_WIDTH-1:0]    hi_lim, lo_lim;
    logic signed [IPS_SAMPLE_WIDTH:0] err_prev, err_prev2;
    pid_result_t increments_q[$];
    int errors;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      setpoint = '0;
      hi_lim = L32_MAX;
      lo_lim = L32_MIN;
      err_prev = '0;
      err_prev2 = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
      case (idx)
        CFG_GAIN_P:       kp = val[GAIN_WIDTH-1:0];
        CFG_GAIN_I:       ki = val[GAIN_WIDTH-1:0];
        CFG_GAIN_D:       kd = val[GAIN_WIDTH-1:0];
        CFG_TARGET_VALUE: setpoint = val[TARGET_WIDTH-1:0];
        CFG_LIMIT_HIGH:   hi_lim = val[LIMIT_WIDTH-1:0];
        CFG_LIMIT_LOW:    lo_lim = val[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [IPS_SAMPLE_WIDTH-1:0] smp);
      logic signed [IPS_SAMPLE_WIDTH:0] err;
      longint d_prop, d_deriv, acc, step;
      pid_result_t r;
      err = (IPS_SAMPLE_WIDTH+1)'(setpoint) - (IPS_SAMPLE_WIDTH+1)'(smp);
      d_prop = longint'(err) - longint'(err_prev);
      d_deriv = longint'(err) - 2 * longint'(err_prev) + longint'(err_prev2);
      acc = longint'(kp) * d_prop + longint'(ki) * longint'(err) - longint'(kd) * d_deriv;
      step = acc >>> IPS_GAIN_FRAC_BITS;
      r.clamped = 1'b0;
      if (step < longint'(lo_lim)) begin
        step = longint'(lo_lim);
        r.clamped = 1'b1;
      end else if (step > longint'(hi_lim)) begin
        step = longint'(hi_lim);
        r.clamped = 1'b1;
      end
      r.increment = step[LIMIT_WIDTH-1:0];
      err_prev2 = err_prev;
      err_prev = err;
      increments_q.push_back(r);
    endfunction

    function int pending();
      return increments_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(logic signed [LIMIT_WIDTH-1:0] inc, logic clamped);
      pid_result_t want;
      if (increments_q.size() == 0) begin
        report($sformatf("result with nothing expected: increment %0d clamped %0b",
                         inc, clamped));
        return;
      end
      want = increments_q.pop_front();
      if (inc !== want.increment)
        report($sformatf("drive_increment %0d, expected %0d", inc, want.increment));
      if (clamped !== want.clamped)
        report($sformatf("was_clamped %0b, expected %0b", clamped, want.clamped));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   calm;
  bit   idle_on;
  int   stall_left;
  int   idle_cycles;
  pid_scoreboard sb;

  ips_sample_if #(.SAMPLE_WIDTH(IPS_SAMPLE_WIDTH)) sample_ch ();
  ips_result_if result_ch ();
  ips_cfg_if    cfg_ch ();

  incremental_pid_step #(
    .SAMPLE_WIDTH(IPS_SAMPLE_WIDTH),
    .GAIN_FRAC_BITS(IPS_GAIN_FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_reg(cfg_ch.index, cfg_ch.data);
      if (sample_ch.valid && sample_ch.ready) sb.note_sample(sample_ch.sample_value);
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.drive_increment, result_ch.was_clamped);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired", $time);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  task automatic send_sample(input logic signed [IPS_SAMPLE_WIDTH-1:0] v);
    if (!calm && idle_on && $urandom_range(0, 4) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample_value <= v;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                         input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c, input bit spare);
    put_reg(CFG_GAIN_P, {16'($urandom), c.gain_p});
    put_reg(CFG_GAIN_I, {16'($urandom), c.gain_i});
    put_reg(CFG_GAIN_D, {16'($urandom), c.gain_d});
    put_reg(CFG_TARGET_VALUE, {16'($urandom), c.target_value});
    put_reg(CFG_LIMIT_HIGH, c.limit_high);
    put_reg(CFG_LIMIT_LOW, c.limit_low);
    if (spare) begin
      put_reg(SPARE_INDEX_A, $urandom);
      put_reg(SPARE_INDEX_B, $urandom);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic cfg_t make_cfg(input logic signed [GAIN_WIDTH-1:0] p, i, d, t,
                                    input logic signed [LIMIT_WIDTH-1:0] hi, lo);
    cfg_t c;
    c.gain_p = p;
    c.gain_i = i;
    c.gain_d = d;
    c.target_value = t;
    c.limit_high = hi;
    c.limit_low = lo;
    return c;
  endfunction

  function automatic logic signed [GAIN_WIDTH-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return S16_MIN;
      1: return S16_MAX;
      2: return '0;
      3: return GAIN_WIDTH'($urandom_range(0, 2047) - 1024);
      default: return GAIN_WIDTH'($urandom);
    endcase
  endfunction

  function automatic cfg_t pick_settings();
    cfg_t c;
    int span;
    c.gain_p = pick_gain();
    c.gain_i = pick_gain();
    c.gain_d = pick_gain();
    c.target_value = TARGET_WIDTH'($urandom);
    case ($urandom_range(0, 4))
      0: begin
        c.limit_high = L32_MAX;
        c.limit_low = L32_MIN;
      end
      1: begin
        span = $urandom_range(0, 1 << 16);
        c.limit_high = span;
        c.limit_low = -span;
      end
      2: begin
        c.limit_high = $urandom_range(0, 1 << 22);
        c.limit_low = -$urandom_range(0, 1 << 22);
      end
      3: begin
        c.limit_low = $urandom_range(0, 1 << 12);
        c.limit_high = -$urandom_range(0, 1 << 12);
      end
      default: begin
        c.limit_high = $urandom;
        c.limit_low = $urandom;
      end
    endcase
    return c;
  endfunction

  initial begin
    int remaining;
    int n;
    logic signed [IPS_SAMPLE_WIDTH-1:0] v;
    cfg_t setting;
    sb = new();
    rst <= 1'b1;
    sample_ch.valid <= 1'b0;
    sample_ch.sample_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    calm = 1'b0;
    idle_on = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_sample(S16_MIN);
    send_sample(S16_MAX);
    wait_drained();
    apply_settings(make_cfg(S16_MAX, S16_MIN, S16_MAX, S16_MIN, L32_MAX, L32_MIN), 1'b0);
    send_sample(S16_MAX);
    send_sample(S16_MIN);
    send_sample(S16_MAX);
    send_sample('0);
    wait_drained();
    apply_settings(make_cfg(S16_MIN, S16_MAX, S16_MIN, S16_MAX, L32_MAX, L32_MIN), 1'b0);
    send_sample(S16_MIN);
    send_sample(S16_MAX);
    send_sample(S16_MIN);
    send_sample(-16'sd1);
    wait_drained();
    apply_settings(make_cfg(16'sd256, '0, '0, '0, 32'sd100, -32'sd100), 1'b0);
    send_sample('0);
    send_sample(-16'sd100);
    send_sample('0);
    send_sample(-16'sd101);
    send_sample('0);
    wait_drained();
    apply_settings(make_cfg(16'sd256, '0, '0, '0, -32'sd50, 32'sd50), 1'b1);
    send_sample('0);
    send_sample(-16'sd10);
    send_sample(-16'sd200);

    remaining = RANDOM_ITEMS;
    while (remaining > 0) begin
      wait_drained();
      if (remaining <= CALM_ITEMS) begin
        calm = 1'b1;
        n = remaining;
      end else begin
        n = $urandom_range(20, 80);
        if (n > remaining - CALM_ITEMS) n = remaining - CALM_ITEMS;
        idle_on = ($urandom_range(0, 3) != 0);
      end
      setting = pick_settings();
      apply_settings(setting, $urandom_range(0, 3) == 0);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0: v = S16_MIN;
          1: v = S16_MAX;
          2, 3: v = IPS_SAMPLE_WIDTH'(setting.target_value + $urandom_range(0, 127) - 64);
          default: v = IPS_SAMPLE_WIDTH'($urandom);
        endcase
        send_sample(v);
      end
      remaining -= n;
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[incremental_pid_step.f]
+incdir+rtl
rtl/ips_pkg.sv
rtl/ips_channels.sv
rtl/ips_cfg_regs.sv
rtl/ips_front.sv
rtl/ips_queue.sv
rtl/ips_back.sv
rtl/incremental_pid_step.sv
test/incremental_pid_step_tb.sv
